/* hw/rtl/vpa_pkg.sv */
// vpa_pkg: beat types, status codes and entry layout for the partition allocator.
// No dependencies.
`default_nettype none
package vpa_pkg;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_HOLE  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_OWNER = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  owner_id;
    logic [15:0] size_request;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic [15:0] base_address;
    logic [15:0] granted_size;
  } out_beat_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [15:0] base;
    logic [15:0] size;
    logic        used;
    logic [7:0]  owner;
  } entry_t;
endpackage
`default_nettype wire

/* hw/rtl/vpa_table.sv */
// vpa_table: partition table memory, one write port, one read port, registered read.
// Depends on vpa_pkg.
`default_nettype none
module vpa_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire vpa_pkg::entry_t  wdata,
  input  wire logic [AW-1:0]    raddr,
  output vpa_pkg::entry_t       rdata
);
  vpa_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/vpa_round.sv */
// vpa_round: rounds a request up to whole granules, one granule minimum.
// Reciprocal multiplication in a three-stage pipeline. Depends on nothing.
`default_nettype none
module vpa_round #(
  parameter int GRANULE = 100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] req,
  output logic             done,
  output logic [16:0]      need
);
  // floor(n / GRANULE) == (n * RECIP) >> SH for every 17-bit n
  localparam int LG = $clog2(GRANULE);
  localparam int SH = 17 + LG;
  localparam int MW = SH + 1;
  localparam int PW = 17 + MW;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(GRANULE) - 64'd1) / 64'(GRANULE);
  localparam logic [MW-1:0] MUL = MW'(RECIP);
  localparam logic [16:0] G   = 17'(GRANULE);
  localparam logic [16:0] GM1 = 17'(GRANULE - 1);

  logic [16:0]   num, blocks, blk1;
  logic [PW-1:0] prod;
  logic [33:0]   grant;
  logic          v1, v2;

  assign prod  = PW'(num) * PW'(MUL);
  assign blk1  = (blocks == 17'd0) ? 17'd1 : blocks;
  assign grant = 34'(blk1) * 34'(G);

  // stage 1: bias for ceiling, stage 2: quotient, stage 3: granted size
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
    if (start) num <= 17'(req) + GM1;
    if (v1) blocks <= prod[SH +: 17];
    if (v2) need <= grant[16:0];
  end
endmodule
`default_nettype wire

/* hw/rtl/variable_partition_allocator.sv */
// variable_partition_allocator: top level, sequencer over the partition table.
// Depends on vpa_pkg, vpa_table, vpa_round.
//
// Usage: one input channel (in_valid/in_stall/in_data), one result channel
// (out_valid/out_stall/out_data), one result beat per input beat. fit_mode is
// written through cfg_we/cfg_data; the user must do so only while the block is
// idle, the block itself does not enforce it. Items are taken one at a time.
// An allocate rounds the request, reduces a stale next-fit start by repeated
// subtraction, then searches slot by slot; on a split the later entries are
// shifted up one slot each. A free searches slot by slot up to the owner's
// entry, then runs a merge sweep over the entries, moving later entries down
// on each merge. The single memory port sets the pace, every visited entry
// costs a read and a write-back slot. out_valid is registered and rises in
// S_OUT, after the result is in out_data.
// Reset is synchronous: slot 0 is written as one free hole covering
// TOTAL_MEMORY in S_INIT after reset, count is one.
// A result sits in the output register until taken; until then no new
// item is accepted.
`default_nettype none
module variable_partition_allocator #(
  parameter int MAX_ENTRIES  = 64,
  parameter int TOTAL_MEMORY = 65500,
  parameter int GRANULE      = 100
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire vpa_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output vpa_pkg::out_beat_t      out_data
);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_ROUND = 5'd2;
  localparam logic [4:0] S_SRD   = 5'd3;
  localparam logic [4:0] S_SCHK  = 5'd4;
  localparam logic [4:0] S_SHRD  = 5'd5;
  localparam logic [4:0] S_SHWR  = 5'd6;
  localparam logic [4:0] S_SPLIT = 5'd7;
  localparam logic [4:0] S_FRD   = 5'd8;
  localparam logic [4:0] S_FCHK  = 5'd9;
  localparam logic [4:0] S_MRD   = 5'd10;
  localparam logic [4:0] S_MCHK  = 5'd11;
  localparam logic [4:0] S_CPRD  = 5'd12;
  localparam logic [4:0] S_CPWR  = 5'd13;
  localparam logic [4:0] S_OUT   = 5'd14;
  localparam logic [4:0] S_MOD   = 5'd15;
  localparam logic [4:0] S_GRANT = 5'd16;

  logic [4:0]    state;
  logic          fit_mode;
  logic [CW-1:0] count;
  logic [AW-1:0] last_slot;
  vpa_pkg::in_beat_t  item;
  vpa_pkg::entry_t    hole, prev;
  logic [CW-1:0] idx, visited, k;
  logic          prev_free;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  vpa_pkg::entry_t wdata, rdata;

  logic        rnd_start, rnd_done;
  logic [16:0] need;

  vpa_table #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  vpa_round #(.GRANULE(GRANULE)) u_round (
    .clk(clk), .rst(rst), .start(rnd_start), .req(in_data.size_request),
    .done(rnd_done), .need(need)
  );

  assign in_stall  = (state != S_IDLE);
  assign rnd_start = (state == S_IDLE) && in_valid && in_data.kind == vpa_pkg::KIND_ALLOC;

  // next index in the circular search
  logic [CW-1:0] idx_inc;
  assign idx_inc = (idx + 1'b1 == count) ? '0 : idx + 1'b1;

  // memory ports, combinational from state
  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{base: 16'd0, size: 16'(TOTAL_MEMORY), used: 1'b0, owner: 8'd0};
      end
      S_SCHK: begin
        // exact fit marks the hole used in place
        if (!rdata.used && {1'b0, rdata.size} >= need && {1'b0, rdata.size} == need) begin
          we = 1'b1;
          wdata = '{base: rdata.base, size: rdata.size, used: 1'b1, owner: item.owner_id};
        end
      end
      S_SHRD:  raddr = AW'(k - 1'b1);
      S_SHWR: begin
        we = 1'b1; waddr = k[AW-1:0]; wdata = rdata;
      end
      S_SPLIT: begin
        we = 1'b1; waddr = AW'(idx + 1'b1);
        wdata = '{base: hole.base + need[15:0], size: hole.size - need[15:0],
                  used: 1'b0, owner: 8'd0};
      end
      S_GRANT: begin
        // granted part stays in the hole's slot
        we = 1'b1;
        wdata = '{base: hole.base, size: need[15:0], used: 1'b1, owner: item.owner_id};
      end
      S_FCHK: begin
        if (rdata.used && rdata.owner == item.owner_id) begin
          we = 1'b1;
          wdata = '{base: rdata.base, size: rdata.size, used: 1'b0, owner: 8'd0};
        end
      end
      S_MCHK: begin
        if (prev_free && !rdata.used) begin
          we = 1'b1; waddr = AW'(idx - 1'b1);
          wdata = '{base: prev.base, size: prev.size + rdata.size, used: 1'b0,
                    owner: prev.owner};
        end
      end
      S_CPRD:  raddr = AW'(k + 1'b1);
      S_CPWR: begin
        we = 1'b1; waddr = k[AW-1:0]; wdata = rdata;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      fit_mode  <= 1'b0;
      count     <= CW'(1);
      last_slot <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) fit_mode <= cfg_data;
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            idx  <= '0;
            visited <= '0;
            prev_free <= 1'b0;
            state <= (in_data.kind == vpa_pkg::KIND_ALLOC) ? S_ROUND : S_FRD;
          end
        end
        S_ROUND: begin
          if (rnd_done) begin
            idx <= fit_mode ? CW'(last_slot) : '0;
            state <= S_MOD;
          end
        end
        // reduce a stale next-fit start below the entry count
        S_MOD: begin
          if (idx >= count) idx <= idx - count;
          else state <= S_SRD;
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (!rdata.used && {1'b0, rdata.size} >= need) begin
            hole <= rdata;
            if ({1'b0, rdata.size} == need) begin
              last_slot <= idx[AW-1:0];
              out_data <= '{status: vpa_pkg::ST_OK, slot_index: 6'(idx),
                            base_address: rdata.base, granted_size: need[15:0]};
              state <= S_OUT;
            end else if (count >= MAXC) begin
              out_data <= '{status: vpa_pkg::ST_FULL, slot_index: 6'd0,
                            base_address: 16'd0, granted_size: 16'd0};
              state <= S_OUT;
            end else begin
              k <= count;
              state <= (count > idx + 1'b1) ? S_SHRD : S_SPLIT;
            end
          end else if (visited + 1'b1 >= count) begin
            out_data <= '{status: vpa_pkg::ST_NO_HOLE, slot_index: 6'd0,
                          base_address: 16'd0, granted_size: 16'd0};
            state <= S_OUT;
          end else begin
            visited <= visited + 1'b1;
            idx <= idx_inc;
            state <= S_SRD;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          k <= k - 1'b1;
          state <= (k - 1'b1 > idx + 1'b1) ? S_SHRD : S_SPLIT;
        end
        S_SPLIT: begin
          count <= count + 1'b1;
          last_slot <= idx[AW-1:0];
          out_data <= '{status: vpa_pkg::ST_OK, slot_index: 6'(idx),
                        base_address: hole.base, granted_size: need[15:0]};
          state <= S_GRANT;
        end
        S_GRANT: state <= S_OUT;
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (rdata.used && rdata.owner == item.owner_id) begin
            out_data <= '{status: vpa_pkg::ST_OK, slot_index: 6'(idx),
                          base_address: rdata.base, granted_size: 16'd0};
            idx <= '0;
            state <= S_MRD;
          end else if (idx + 1'b1 >= count) begin
            out_data <= '{status: vpa_pkg::ST_NO_OWNER, slot_index: 6'd0,
                          base_address: 16'd0, granted_size: 16'd0};
            state <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
            state <= S_FRD;
          end
        end
        S_MRD: state <= (idx >= count) ? S_OUT : S_MCHK;
        S_MCHK: begin
          if (prev_free && !rdata.used) begin
            prev <= '{base: prev.base, size: prev.size + rdata.size, used: 1'b0,
                      owner: prev.owner};
            k <= idx;
            count <= count - 1'b1;
            state <= (idx + 1'b1 < count) ? S_CPRD : S_MRD;
          end else begin
            prev <= rdata;
            prev_free <= !rdata.used;
            idx <= idx + 1'b1;
            state <= S_MRD;
          end
        end
        S_CPRD: state <= S_CPWR;
        S_CPWR: begin
          k <= k + 1'b1;
          state <= (k + 2'd2 < count + 1'b1) ? S_CPRD : S_MRD;
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/vpa_checker.sv */
// vpa_checker: port-level checks for variable_partition_allocator, with bind.
// Depends on vpa_pkg.
`default_nettype none
module vpa_port_checks (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire vpa_pkg::out_beat_t out_data
);
  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // no input taken while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open with result pending");
  // failed items report slot zero
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != vpa_pkg::ST_OK |-> out_data.slot_index == 6'd0)
    else $error("failure with nonzero slot");
endmodule

bind variable_partition_allocator vpa_port_checks u_vpa_port_checks (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
